// ----- rtl/core/trae_pkg.sv -----
package trae_pkg;

  // opcodes of the instruction field
  localparam logic [3:0] OP_CLEAR  = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_MOVE   = 4'd2;
  localparam logic [3:0] OP_ADD    = 4'd3;
  localparam logic [3:0] OP_ADD3   = 4'd4;
  localparam logic [3:0] OP_SUB    = 4'd5;
  localparam logic [3:0] OP_SUB3   = 4'd6;
  localparam logic [3:0] OP_SQUARE = 4'd7;
  localparam logic [3:0] OP_ROOT   = 4'd8;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [2:0]         first_reg;
    logic [2:0]         second_reg;
    logic [2:0]         third_reg;
    logic signed [31:0] immediate;
    logic [1:0]         operand_count;
  } instr_t;

  typedef struct packed {
    logic [2:0]         changed_register;
    logic signed [31:0] new_value;
    logic               did_write;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_A,
    S_READ_B,
    S_LOAD,
    S_EXEC,
    S_SQUARE,
    S_ROOT,
    S_DONE
  } state_t;

endpackage

// ----- rtl/core/trae_ram.sv -----
module trae_ram
  import trae_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/toy_register_alu_execute_top.sv -----
// channel | direction | handshake                   | payload
// instr   | in        | instr_valid / instr_ready   | instr_t  (one decoded instruction)
// result  | out       | result_valid / result_ready | result_t (register written, new value)
//
// an item passes idle, read, load, execute, done; a square or the root of a non-negative value
// loops in S_SQUARE or S_ROOT; the shared adder does one radix-4 digit or one root bit a cycle
// the register file is read through one registered port, operands one after the other
// synchronous reset clears the per-register valid bits, so every register reads as zero
// a result held in the output register does not stop the next item from being taken;
// a finished item waits in its last state only while the output register is still full

module toy_register_alu_execute_top
  import trae_pkg::*;
#(
  parameter int NUM_REGS   = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    instr_valid,
  output logic    instr_ready,
  input  instr_t  instr,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int W  = DATA_WIDTH;
  localparam int AW = $clog2(NUM_REGS);
  localparam int IW = (AW >= 3) ? AW + 1 : 3;   // wide enough to compare with NUM_REGS
  localparam int K  = (W + 1) / 2;               // digits of square, bits of root
  localparam int MW = 2 * K;
  localparam int CW = $clog2(K);

  state_t state, state_next;

  instr_t              item;        // instruction under way
  logic [W-1:0]        opx;         // first operand
  logic [W-1:0]        opy;         // second operand
  logic [W-1:0]        triple;      // three times the first operand
  logic [W-1:0]        work;        // square accumulator, or root remainder
  logic [MW-1:0]       mplier;      // square multiplier digits, top first
  logic [W-1:0]        root;
  logic [W-1:0]        probe;       // one-hot root trial bit
  logic [CW-1:0]       step;
  logic [W-1:0]        res_val;
  logic [NUM_REGS-1:0] written;     // register holds a written value

  // shared adder
  logic [W-1:0] add_a, add_b;
  logic         add_sub;
  logic [W:0]   add_sum;

  // register file port
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [W-1:0]  ram_rdata;

  // operand and destination decode
  logic [IW-1:0] a_ext, b_ext, d_ext;
  logic [AW-1:0] a_addr, b_addr, d_addr;
  logic          a_ok, b_ok, wr_ok, known;
  logic [2:0]    dest;
  logic [63:0]   imm64, val64;
  logic          out_free;
  logic [W-1:0]  root_try;

  assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (W+1)'(add_sub);

  always_comb begin
    case (item.opcode)
      OP_ADD3, OP_SUB3:    dest = item.third_reg;
      OP_SQUARE, OP_ROOT:  dest = (item.operand_count == 2'd1) ? item.first_reg
                                                               : item.second_reg;
      default:             dest = item.first_reg;
    endcase
  end

  assign known  = item.opcode inside {[OP_CLEAR:OP_ROOT]};
  assign a_ext  = IW'(item.first_reg);
  assign b_ext  = IW'(item.second_reg);
  assign d_ext  = IW'(dest);
  assign a_addr = a_ext[AW-1:0];
  assign b_addr = b_ext[AW-1:0];
  assign d_addr = d_ext[AW-1:0];
  // a register never written, or out of range, reads as zero
  assign a_ok   = (a_ext < IW'(NUM_REGS)) && written[a_addr];
  assign b_ok   = (b_ext < IW'(NUM_REGS)) && written[b_addr];
  assign wr_ok  = known && (d_ext < IW'(NUM_REGS));

  assign imm64    = {{32{item.immediate[31]}}, item.immediate};
  assign val64    = 64'(res_val);
  assign out_free = !result_valid || result_ready;
  assign root_try = (root >> 1) | probe;

  trae_ram #(
    .WIDTH (W),
    .DEPTH (NUM_REGS)
  ) u_regs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (d_addr),
    .wdata (res_val),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (instr_valid) state_next = S_READ_A;
      S_READ_A: state_next = S_READ_B;
      S_READ_B: state_next = S_LOAD;
      S_LOAD:   state_next = S_EXEC;
      S_EXEC: begin
        if (item.opcode == OP_SQUARE) begin
          state_next = S_SQUARE;
        end else if (item.opcode == OP_ROOT && !opx[W-1]) begin
          state_next = S_ROOT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SQUARE, S_ROOT: if (step == '0) state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // control outputs and adder operands
  always_comb begin
    instr_ready = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = a_addr;
    add_a       = opx;
    add_b       = opy;
    add_sub     = 1'b0;
    case (state)
      S_IDLE:   instr_ready = 1'b1;
      S_READ_B: ram_raddr = b_addr;
      S_EXEC: begin
        if (item.opcode == OP_SUB || item.opcode == OP_SUB3) begin
          add_sub = 1'b1;
        end else if (item.opcode == OP_SQUARE) begin
          add_a = opx << 1;
          add_b = opx;
        end
      end
      S_SQUARE: begin
        add_a = work << 2;
        case (mplier[MW-1 -: 2])
          2'd0:    add_b = '0;
          2'd1:    add_b = opx;
          2'd2:    add_b = opx << 1;
          default: add_b = triple;
        endcase
      end
      S_ROOT: begin
        add_a   = work;
        add_b   = root | probe;
        add_sub = 1'b1;
      end
      S_DONE:   ram_we = out_free && wr_ok;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE:   if (instr_valid) item <= instr;
      S_READ_B: opx <= a_ok ? ram_rdata : '0;
      S_LOAD:   opy <= b_ok ? ram_rdata : '0;
      S_EXEC: begin
        step <= CW'(K - 1);
        case (item.opcode)
          OP_LOAD:                         res_val <= imm64[W-1:0];
          OP_MOVE:                         res_val <= opy;
          OP_ADD, OP_ADD3, OP_SUB, OP_SUB3: res_val <= add_sum[W-1:0];
          OP_SQUARE: begin
            triple <= add_sum[W-1:0];
            work   <= '0;
            mplier <= MW'(opx);
          end
          OP_ROOT: begin
            // negative input leaves zero
            res_val <= '0;
            work    <= opx;
            root    <= '0;
            probe   <= W'(1) << (2 * K - 2);
          end
          default:                         res_val <= '0;
        endcase
      end
      S_SQUARE: begin
        work    <= add_sum[W-1:0];
        res_val <= add_sum[W-1:0];
        mplier  <= mplier << 2;
        step    <= step - 1'b1;
      end
      S_ROOT: begin
        // carry out means remainder covers the trial value
        if (add_sum[W]) begin
          work    <= add_sum[W-1:0];
          root    <= root_try;
          res_val <= root_try;
        end else begin
          root    <= root >> 1;
          res_val <= root >> 1;
        end
        probe <= probe >> 2;
        step  <= step - 1'b1;
      end
      default: ;
    endcase
  end

  // valid bits of the register file
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (ram_we) begin
      written[d_addr] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      result.did_write        <= wr_ok;
      result.changed_register <= wr_ok ? dest : 3'd0;
      result.new_value        <= wr_ok ? val64[31:0] : 32'd0;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    instr_valid && instr_ready |=> !instr_ready)
    else $error("instruction taken while one is under way");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.did_write |->
      result.changed_register == 3'd0 && result.new_value == 32'd0)
    else $error("result without a write carries a register or value");

  a_dest_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.did_write |-> result.changed_register < NUM_REGS)
    else $error("write reported beyond the register file");

  a_root_probe: assert property (@(posedge clk) disable iff (rst)
    state == S_ROOT |-> $onehot(probe))
    else $error("root trial bit lost");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> written == '0)
    else $error("register valid bits survive reset");

endmodule
